// ===== rtl/core/sbl_pkg.sv =====
// sbl_pkg: shared types and constants of the stack blur line filter
// no dependencies; imported by every module of the filter
`default_nettype none

package sbl_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int NUM_CHAN     = 3;
  localparam int PIXEL_W      = NUM_CHAN * CHANNEL_BITS;
  localparam int RADIUS_W     = 8;
  localparam int MUL_W        = 10;
  localparam int SHIFT_W      = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 10;

  localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = 8'd255;
  localparam logic [MUL_W-1:0]        MUL_RST  = 10'd512;
  localparam logic [SHIFT_W-1:0]      SHIFT_RST = 5'd9;

  // channel 0 is red, in the lowest bits
  typedef logic [NUM_CHAN-1:0][CHANNEL_BITS-1:0] pixel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS      = 2'd0,
    REG_SCALE_MUL   = 2'd1,
    REG_SCALE_SHIFT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  // fill loads the whole window at line start, step moves it by one pixel
  typedef struct packed {
    logic fill;
    logic step;
  } step_ctrl_t;

  typedef struct packed {
    logic [MUL_W-1:0]   mul;
    logic [SHIFT_W-1:0] shift;
  } scale_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbl_cell.sv =====
// sbl_cell: one pixel cell of the window delay chain
// depends on sbl_pkg
`default_nettype none

module sbl_cell
  import sbl_pkg::*;
(
  input  wire        clk_i,
  input  step_ctrl_t ctrl_i,
  input  wire        inject_i,
  input  pixel_t     fill_i,
  input  pixel_t     inject_data_i,
  input  pixel_t     prev_i,
  output pixel_t     data_o
);

  pixel_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.fill) begin
      data_d = fill_i;
    end else if (ctrl_i.step) begin
      data_d = inject_i ? inject_data_i : prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/sbl_chain.sv =====
// sbl_chain: row of pixel cells forming a delay line of selectable length
// depends on sbl_pkg and sbl_cell
`default_nettype none

module sbl_chain
  import sbl_pkg::*;
#(
  parameter int DEPTH = 254
) (
  input  wire                 clk_i,
  input  step_ctrl_t          ctrl_i,
  input  wire  [RADIUS_W-1:0] len_i,
  input  pixel_t              fill_i,
  input  pixel_t              inject_data_i,
  output pixel_t              tail_o
);

  pixel_t cell_data [DEPTH];

  // a pixel enters len cells before the tail and leaves the tail len steps later
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    localparam logic [RADIUS_W-1:0] POS = RADIUS_W'(DEPTH - j);
    pixel_t prev;

    if (j == 0) begin : g_head
      assign prev = inject_data_i;
    end else begin : g_body
      assign prev = cell_data[j-1];
    end

    sbl_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl_i),
      .inject_i      (len_i == POS),
      .fill_i        (fill_i),
      .inject_data_i (inject_data_i),
      .prev_i        (prev),
      .data_o        (cell_data[j])
    );
  end

  assign tail_o = cell_data[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/core/sbl_accum.sv =====
// sbl_accum: weighted sum and the two half sums of each color channel
// depends on sbl_pkg
`default_nettype none

module sbl_accum
  import sbl_pkg::*;
#(
  parameter int WS_W = 24,
  parameter int HS_W = 16,
  parameter int SQ_W = 16
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  step_ctrl_t                      ctrl_i,
  input  wire  [RADIUS_W-1:0]             radius_i,
  input  wire  [SQ_W-1:0]                 radius_sq_i,
  input  pixel_t                          new_px_i,
  input  pixel_t                          mid_px_i,
  input  pixel_t                          old_px_i,
  output logic [NUM_CHAN-1:0][WS_W-1:0]   ws_next_o
);

  logic [NUM_CHAN-1:0][WS_W-1:0] ws_q, ws_d;
  logic [NUM_CHAN-1:0][HS_W-1:0] in_q, in_d;
  logic [NUM_CHAN-1:0][HS_W-1:0] out_q, out_d;
  logic [RADIUS_W:0]             r_plus1;

  assign r_plus1 = {1'b0, radius_i} + (RADIUS_W+1)'(1);

  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_chan
    logic [SQ_W+CHANNEL_BITS-1:0]     ws_start;
    logic [RADIUS_W+CHANNEL_BITS:0]   hs_start;
    logic [CHANNEL_BITS-1:0]          nv, mid, old;

    assign nv       = new_px_i[ch];
    assign mid      = mid_px_i[ch];
    assign old      = old_px_i[ch];
    assign ws_start = (SQ_W+CHANNEL_BITS)'(radius_sq_i) * (SQ_W+CHANNEL_BITS)'(nv);
    assign hs_start = (RADIUS_W+CHANNEL_BITS+1)'(r_plus1)
                      * (RADIUS_W+CHANNEL_BITS+1)'(nv);

    always_comb begin
      ws_d[ch]  = ws_q[ch];
      in_d[ch]  = in_q[ch];
      out_d[ch] = out_q[ch];
      if (ctrl_i.fill) begin
        ws_d[ch]  = WS_W'(ws_start);
        out_d[ch] = HS_W'(hs_start);
        in_d[ch]  = HS_W'(hs_start - (RADIUS_W+CHANNEL_BITS+1)'(nv));
      end else if (ctrl_i.step) begin
        ws_d[ch]  = ws_q[ch] + WS_W'(in_q[ch]) - WS_W'(out_q[ch]) + WS_W'(nv);
        out_d[ch] = out_q[ch] + HS_W'(mid) - HS_W'(old);
        in_d[ch]  = in_q[ch] + HS_W'(nv) - HS_W'(mid);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q  <= '0;
      in_q  <= '0;
      out_q <= '0;
    end else begin
      ws_q  <= ws_d;
      in_q  <= in_d;
      out_q <= out_d;
    end
  end

  assign ws_next_o = ws_d;

endmodule

`default_nettype wire

// ===== rtl/core/sbl_scale.sv =====
// sbl_scale: reciprocal multiply, shift and saturation with output register
// depends on sbl_pkg
`default_nettype none

module sbl_scale
  import sbl_pkg::*;
#(
  parameter int WS_W = 24
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  scale_cfg_t                     cfg_i,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [NUM_CHAN-1:0][WS_W-1:0]  in_ws_i,
  input  wire                            in_end_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output pixel_t                         out_px_o,
  output logic                           out_end_o
);

  localparam int PROD_W = WS_W + MUL_W;

  logic                              vw_q, vp_q, vo_q;
  logic                              endw_q, endp_q, endo_q;
  logic [NUM_CHAN-1:0][WS_W-1:0]     ws_q;
  logic [NUM_CHAN-1:0][PROD_W-1:0]   prod_q, prod_d;
  pixel_t                            px_q, px_d;
  logic                              ready_o_stage, ready_p_stage, ready_w_stage;

  assign ready_o_stage = !vo_q || out_ready_i;
  assign ready_p_stage = !vp_q || ready_o_stage;
  assign ready_w_stage = !vw_q || ready_p_stage;
  assign in_ready_o    = ready_w_stage;

  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_chan
    logic [PROD_W-1:0] shifted;

    assign prod_d[ch] = PROD_W'(ws_q[ch]) * PROD_W'(cfg_i.mul);
    assign shifted    = prod_q[ch] >> cfg_i.shift;
    assign px_d[ch]   = (|shifted[PROD_W-1:CHANNEL_BITS]) ? CHAN_MAX
                                                         : shifted[CHANNEL_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q <= 1'b0;
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ready_w_stage) vw_q <= in_valid_i;
      if (ready_p_stage) vp_q <= vw_q;
      if (ready_o_stage) vo_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_w_stage && in_valid_i) begin
      ws_q   <= in_ws_i;
      endw_q <= in_end_i;
    end
    if (ready_p_stage && vw_q) begin
      prod_q <= prod_d;
      endp_q <= endw_q;
    end
    if (ready_o_stage && vp_q) begin
      px_q   <= px_d;
      endo_q <= endp_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_px_o    = px_q;
  assign out_end_o   = endo_q;

endmodule

`default_nettype wire

// ===== rtl/core/stack_blur_line_filter.sv =====
// stack_blur_line_filter: top level of the stack blur line filter
// depends on sbl_pkg, sbl_chain, sbl_accum and sbl_scale
`default_nettype none

// Filters a line of RGB pixels with the stack blur triangle kernel of radius R,
// edges replicated. One item (pixel or drain) is taken every cycle unless the
// output stalls; the running sums are updated in the cycle an item is accepted
// and the result leaves through the output register, behind a weighted-sum
// snapshot stage and the reciprocal multiply stage. The window is a chain of
// 2*MAX_RADIUS+1 pixel cells that move one step per pixel and are all loaded
// with the first pixel of a line, so there is no clearing pass. Output c comes
// out with pixel c+R; after the last pixel send R drain items. R is taken from
// the radius register at the first pixel of each line and saturates at
// MAX_RADIUS. The user must write registers only while idle; nothing checks it.
module stack_blur_line_filter
  import sbl_pkg::*;
#(
  parameter int MAX_RADIUS = 254
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // configuration writes
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire  [PIXEL_W-1:0]     s_axis_tdata,   // red_in, green_in, blue_in
  input  wire  [1:0]             s_axis_tuser,   // cmd, first_of_line
  input  wire                    s_axis_tlast,   // last_of_line
  // output stream
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  output logic [PIXEL_W-1:0]     m_axis_tdata,   // red_out, green_out, blue_out
  output logic                   m_axis_tlast    // line_end
);

  localparam int WS_W = $clog2((MAX_RADIUS+1) * (MAX_RADIUS+1) * 255 + 1);
  localparam int HS_W = $clog2((MAX_RADIUS+1) * 255 + 1);
  localparam int SQ_W = $clog2((MAX_RADIUS+1) * (MAX_RADIUS+1) + 1);
  localparam logic [RADIUS_W-1:0] RADIUS_CAP = RADIUS_W'(MAX_RADIUS);

  // configuration registers
  logic [RADIUS_W-1:0] radius_q;
  logic [SQ_W-1:0]     radius_sq_q;
  scale_cfg_t          scale_q;
  logic [RADIUS_W-1:0] cfg_radius;
  logic [RADIUS_W:0]   cfg_r_plus1;
  logic [2*RADIUS_W+1:0] cfg_sq;

  assign cfg_ready_o = 1'b1;
  assign cfg_radius  = (cfg_data_i[RADIUS_W-1:0] > RADIUS_CAP) ? RADIUS_CAP
                                                               : cfg_data_i[RADIUS_W-1:0];
  assign cfg_r_plus1 = {1'b0, cfg_radius} + (RADIUS_W+1)'(1);
  assign cfg_sq      = (2*RADIUS_W+2)'(cfg_r_plus1) * (2*RADIUS_W+2)'(cfg_r_plus1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= '0;
      radius_sq_q   <= SQ_W'(1);
      scale_q.mul   <= MUL_RST;
      scale_q.shift <= SHIFT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RADIUS: begin
          radius_q    <= cfg_radius;
          radius_sq_q <= SQ_W'(cfg_sq);
        end
        REG_SCALE_MUL:   scale_q.mul   <= cfg_data_i[MUL_W-1:0];
        REG_SCALE_SHIFT: scale_q.shift <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // line state
  logic [RADIUS_W-1:0] line_r_q, line_r_d;
  logic                open_q, open_d;
  logic [RADIUS_W-1:0] drain_q, drain_d;
  logic [RADIUS_W-1:0] lead_q, lead_d;
  pixel_t              edge_q, edge_d;

  logic        accept, is_drain, drain_ok, start, push, emit, emit_end;
  logic        first_in, last_in;
  logic [RADIUS_W-1:0] r_use;
  pixel_t      px_in, px_sel, mid_px, a_tail, b_tail;
  step_ctrl_t  ctrl;
  logic        scale_ready;
  logic [NUM_CHAN-1:0][WS_W-1:0] ws_next;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_drain = (cmd_e'(s_axis_tuser[0]) == CMD_DRAIN);
  assign first_in = s_axis_tuser[1];
  assign last_in  = s_axis_tlast;
  assign px_in    = s_axis_tdata;

  // a drain counts only after the last pixel and while drains are pending
  assign drain_ok = is_drain && !open_q && (drain_q != '0);
  assign start    = !is_drain && (first_in || !open_q);
  assign push     = drain_ok || (!is_drain && !start);
  assign r_use    = start ? radius_q : line_r_q;
  assign px_sel   = is_drain ? edge_q : px_in;
  assign mid_px   = (line_r_q == '0) ? px_sel : a_tail;

  assign ctrl.fill = accept && start;
  assign ctrl.step = accept && push;

  always_comb begin
    line_r_d = line_r_q;
    open_d   = open_q;
    drain_d  = drain_q;
    lead_d   = lead_q;
    edge_d   = edge_q;
    emit     = 1'b0;
    emit_end = 1'b0;
    if (start) begin
      line_r_d = radius_q;
      open_d   = 1'b1;
      drain_d  = '0;
      lead_d   = '0;
      edge_d   = px_in;
    end else if (push) begin
      edge_d = px_sel;
      if (lead_q < line_r_q) begin
        lead_d = lead_q + RADIUS_W'(1);
      end
    end
    if (drain_ok) begin
      drain_d  = drain_q - RADIUS_W'(1);
      emit     = 1'b1;
      emit_end = (drain_q == RADIUS_W'(1));
    end else if (!is_drain) begin
      if (last_in) begin
        open_d  = 1'b0;
        drain_d = r_use;
      end
      emit     = (lead_d >= r_use);
      emit_end = last_in && (r_use == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_r_q <= '0;
      open_q   <= 1'b0;
      drain_q  <= '0;
      lead_q   <= '0;
      edge_q   <= '0;
    end else if (accept) begin
      line_r_q <= line_r_d;
      open_q   <= open_d;
      drain_q  <= drain_d;
      lead_q   <= lead_d;
      edge_q   <= edge_d;
    end
  end

  // first half of the window: tail gives the pixel R steps old
  sbl_chain #(
    .DEPTH (MAX_RADIUS)
  ) u_chain_a (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .len_i         (line_r_q),
    .fill_i        (px_in),
    .inject_data_i (px_sel),
    .tail_o        (a_tail)
  );

  // second half: tail gives the pixel 2R+1 steps old
  sbl_chain #(
    .DEPTH (MAX_RADIUS + 1)
  ) u_chain_b (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .len_i         (line_r_q + RADIUS_W'(1)),
    .fill_i        (px_in),
    .inject_data_i (mid_px),
    .tail_o        (b_tail)
  );

  sbl_accum #(
    .WS_W (WS_W),
    .HS_W (HS_W),
    .SQ_W (SQ_W)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .radius_i    (radius_q),
    .radius_sq_i (radius_sq_q),
    .new_px_i    (px_sel),
    .mid_px_i    (mid_px),
    .old_px_i    (b_tail),
    .ws_next_o   (ws_next)
  );

  assign s_axis_tready = scale_ready;

  sbl_scale #(
    .WS_W (WS_W)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (scale_q),
    .in_valid_i  (accept && emit),
    .in_ready_o  (scale_ready),
    .in_ws_i     (ws_next),
    .in_end_i    (emit_end),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_px_o    (m_axis_tdata),
    .out_end_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for stack_blur_line_filter
// depends on sbl_pkg and the filter rtl; predicts every blurred pixel and checks the stream
`timescale 1ns / 100ps

module tb_top;
  import sbl_pkg::*;

  localparam int MAX_RAD     = 254;
  localparam int RING_DEPTH  = 2 * MAX_RAD + 1;
  localparam int PHASE_ITEMS = 110;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    cmd_e   cmd;
    logic   first;
    logic   last;
    pixel_t px;
  } line_item_t;

  typedef struct {
    pixel_t px;
    logic   line_end;
  } blur_out_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIXEL_W-1:0]    s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [PIXEL_W-1:0]    m_tdata;
  logic                  m_tlast;

  stack_blur_line_filter #(
    .MAX_RADIUS(MAX_RAD)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state, mirrors the register file and the running sums
  int unsigned cur_rad = 0;
  logic [MUL_W-1:0]   cur_mul = MUL_RST;
  logic [SHIFT_W-1:0] cur_shift = SHIFT_RST;

  pixel_t      window [RING_DEPTH];
  logic [31:0] wsum [NUM_CHAN];
  logic [31:0] in_half [NUM_CHAN];
  logic [31:0] out_half [NUM_CHAN];
  pixel_t      edge_px = '0;
  int unsigned ring_ptr = 0;
  int unsigned lead = 0;
  int unsigned line_rad = 0;
  bit          line_open = 1'b0;
  int unsigned drains_left = 0;

  line_item_t pending_items [$];
  blur_out_t  expected_pixels [$];
  int unsigned n_queued = 0;
  int unsigned n_errors = 0;
  string chan_name [NUM_CHAN] = '{"red", "green", "blue"};

  initial begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      wsum[ch] = '0;
      in_half[ch] = '0;
      out_half[ch] = '0;
    end
  end

  function automatic void slide_window(pixel_t px);
    int unsigned d, p, mid_idx;
    pixel_t old, mid;
    d = 2 * line_rad + 1;
    p = (ring_ptr < d) ? ring_ptr : 0;
    old = window[p];
    window[p] = px;
    edge_px = px;
    mid_idx = (p + line_rad + 1) % d;
    mid = window[mid_idx];
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      wsum[ch] = wsum[ch] + in_half[ch] - out_half[ch] + 32'(px[ch]);
      out_half[ch] = out_half[ch] + 32'(mid[ch]) - 32'(old[ch]);
      in_half[ch] = in_half[ch] + 32'(px[ch]) - 32'(mid[ch]);
    end
    ring_ptr = (p + 1) % d;
    if (lead < line_rad) lead++;
  endfunction

  function automatic void push_blurred(logic end_flag);
    blur_out_t r;
    logic [63:0] v;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      v = (64'(wsum[ch]) * 64'(cur_mul)) >> cur_shift;
      r.px[ch] = (v > 64'(CHAN_MAX)) ? CHAN_MAX : v[7:0];
    end
    r.line_end = end_flag;
    expected_pixels.push_back(r);
  endfunction

  function automatic void blur_step(line_item_t it);
    int unsigned r;
    if (it.cmd == CMD_DRAIN) begin
      if (line_open || drains_left == 0) return;
      slide_window(edge_px);
      drains_left--;
      push_blurred(drains_left == 0);
      return;
    end
    if (it.first || !line_open) begin
      r = (cur_rad > MAX_RAD) ? MAX_RAD : cur_rad;
      line_rad = r;
      for (int i = 0; i < 2 * r + 1; i++) window[i] = it.px;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        wsum[ch] = 32'((r + 1) * (r + 1) * 32'(it.px[ch]));
        out_half[ch] = 32'((r + 1) * 32'(it.px[ch]));
        in_half[ch] = 32'(r * 32'(it.px[ch]));
      end
      edge_px = it.px;
      ring_ptr = 0;
      lead = 0;
      line_open = 1'b1;
      drains_left = 0;
    end else begin
      slide_window(it.px);
    end
    if (it.last) begin
      line_open = 1'b0;
      drains_left = line_rad;
    end
    if (lead >= line_rad) push_blurred(it.last && line_rad == 0);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  // request driver: bursts of random length with random gaps between them
  line_item_t  cur_item;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) blur_step(cur_item);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur_item.px;
          s_tuser  <= {cur_item.first, cur_item.cmd};
          s_tlast  <= cur_item.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own stall pattern
  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin : monitor
    blur_out_t want;
    pixel_t got;
    cycle_cnt++;
    case ((cycle_cnt >> 8) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 7) != 0);
      default: m_tready <= ((cycle_cnt % 32) < 12);
    endcase
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_pixels.size() == 0) begin
        report_mismatch("output request with no result expected");
      end else begin
        want = expected_pixels.pop_front();
        for (int ch = 0; ch < NUM_CHAN; ch++)
          if (got[ch] !== want.px[ch])
            report_mismatch($sformatf("%s got %0d expected %0d",
                                      chan_name[ch], got[ch], want.px[ch]));
        if (m_tlast !== want.line_end)
          report_mismatch($sformatf("line_end got %b expected %b", m_tlast, want.line_end));
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (rst_ni && quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus
  function automatic pixel_t rand_pixel();
    pixel_t px;
    for (int ch = 0; ch < NUM_CHAN; ch++)
      case ($urandom_range(0, 7))
        0: px[ch] = 8'd0;
        1: px[ch] = 8'd255;
        default: px[ch] = 8'($urandom_range(0, 255));
      endcase
    return px;
  endfunction

  task automatic queue_item(cmd_e c, logic f, logic l, pixel_t px);
    line_item_t it;
    it.cmd = c;
    it.first = f;
    it.last = l;
    it.px = px;
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic queue_line(int unsigned len, int unsigned drains, bit loose_start);
    for (int unsigned i = 0; i < len; i++) begin
      // stray drain among the pixels of a line
      if ($urandom_range(0, 24) == 0)
        queue_item(CMD_DRAIN, 1'($urandom), 1'($urandom), rand_pixel());
      queue_item(CMD_PIXEL, (i == 0) ? !loose_start : ($urandom_range(0, 39) == 0),
                 i == len - 1, rand_pixel());
    end
    repeat (drains) queue_item(CMD_DRAIN, 1'($urandom), 1'($urandom), rand_pixel());
  endtask

  task automatic fill_phase(int unsigned rad, int unsigned target);
    int unsigned r_eff, len, start, pick;
    r_eff = (rad > MAX_RAD) ? MAX_RAD : rad;
    start = n_queued;
    while (n_queued - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if ($urandom_range(0, 3) == 0) len = $urandom_range(1, r_eff + 1);
        else len = $urandom_range(1, (r_eff < 20) ? 3 * r_eff + 10 : 24);
        queue_line(len, r_eff, 1'b0);
      end else if (pick < 88) begin
        // cut the drains short so the next line drops them
        queue_line($urandom_range(1, 8), $urandom_range(0, r_eff), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, 3))
          queue_item(CMD_DRAIN, 1'($urandom), 1'($urandom), rand_pixel());
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || s_tvalid || expected_pixels.size() != 0)
      @(posedge clk_i);
    // ignored drains give no result, so let the pipeline settle
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RADIUS:      cur_rad = 32'(val[RADIUS_W-1:0]);
      REG_SCALE_MUL:   cur_mul = val[MUL_W-1:0];
      REG_SCALE_SHIFT: cur_shift = val[SHIFT_W-1:0];
      default: ;
    endcase
  endtask

  int unsigned fixed_rad   [10] = '{1, 3, 0, 5, 7, 255, 16, 2, 254, 4};
  int unsigned fixed_mul   [10] = '{128, 32, 0, 512, 8, 1, 2, 512, 1, 341};
  int unsigned fixed_shift [10] = '{9, 9, 0, 0, 9, 16, 9, 31, 16, 13};

  initial begin
    int unsigned rad, mul, shift;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, radius zero: every pixel comes straight back
    queue_item(CMD_PIXEL, 1'b1, 1'b0, 24'h000000);
    queue_item(CMD_PIXEL, 1'b0, 1'b0, 24'hFFFFFF);
    queue_item(CMD_PIXEL, 1'b0, 1'b1, 24'hC3A55A);
    queue_item(CMD_DRAIN, 1'b0, 1'b0, 24'h000000);
    wait_idle();

    write_reg(REG_RADIUS, 10'd2);
    write_reg(REG_SCALE_MUL, 10'd57);
    write_reg(REG_SCALE_SHIFT, 10'd9);
    queue_item(CMD_DRAIN, 1'b1, 1'b1, 24'hFFFFFF);
    queue_item(CMD_PIXEL, 1'b1, 1'b0, 24'hFFFFFF);
    queue_item(CMD_PIXEL, 1'b0, 1'b0, 24'h000000);
    queue_item(CMD_DRAIN, 1'b0, 1'b0, 24'h123456);
    queue_item(CMD_PIXEL, 1'b0, 1'b0, 24'h808080);
    queue_item(CMD_PIXEL, 1'b0, 1'b1, 24'h7FFE01);
    queue_item(CMD_DRAIN, 1'b0, 1'b0, 24'h000000);
    queue_item(CMD_DRAIN, 1'b1, 1'b0, 24'hFFFFFF);
    queue_item(CMD_DRAIN, 1'b0, 1'b1, 24'hAAAAAA);
    // one-pixel line, outputs only during the drains
    queue_item(CMD_PIXEL, 1'b1, 1'b1, 24'h123456);
    queue_item(CMD_DRAIN, 1'b0, 1'b0, 24'h555555);
    queue_item(CMD_DRAIN, 1'b0, 1'b0, 24'h555555);
    // pixel with no open line starts one; a new first pixel drops pending drains
    queue_item(CMD_PIXEL, 1'b0, 1'b0, 24'h00FF00);
    queue_item(CMD_PIXEL, 1'b0, 1'b1, 24'hFF00FF);
    queue_item(CMD_DRAIN, 1'b0, 1'b0, 24'h000000);
    queue_item(CMD_PIXEL, 1'b1, 1'b1, 24'hFF0000);
    queue_item(CMD_DRAIN, 1'b0, 1'b0, 24'h000000);
    queue_item(CMD_DRAIN, 1'b0, 1'b0, 24'h000000);
    wait_idle();

    for (int ph = 0; ph < 15; ph++) begin
      if (ph < 10) begin
        rad = fixed_rad[ph];
        mul = fixed_mul[ph];
        shift = fixed_shift[ph];
      end else begin
        rad = $urandom_range(0, 12);
        shift = $urandom_range(4, 20);
        mul = (1 << shift) / ((rad + 1) * (rad + 1));
        if (mul > 512 || $urandom_range(0, 3) == 0) mul = $urandom_range(0, 512);
      end
      write_reg(REG_RADIUS, CFG_DATA_W'(rad));
      write_reg(REG_SCALE_MUL, CFG_DATA_W'(mul));
      write_reg(REG_SCALE_SHIFT, CFG_DATA_W'(shift));
      fill_phase(rad, PHASE_ITEMS);
      wait_idle();
    end

    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== stack_blur_line_filter.f =====
rtl/core/sbl_pkg.sv
rtl/core/sbl_cell.sv
rtl/core/sbl_chain.sv
rtl/core/sbl_accum.sv
rtl/core/sbl_scale.sv
rtl/core/stack_blur_line_filter.sv
tb/tb_top.sv
